/* rtl/core/md5_pkg.sv */
// Package for the MD5 digest unit: state codes, controller commands,
// round constants and the small round functions. Depends on nothing.
package md5_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 64;
  localparam int unsigned Words  = 16;
  localparam int unsigned Rounds = 64;

  localparam logic [WordW-1:0] INIT_A = 32'h67452301;
  localparam logic [WordW-1:0] INIT_B = 32'hefcdab89;
  localparam logic [WordW-1:0] INIT_C = 32'h98badcfe;
  localparam logic [WordW-1:0] INIT_D = 32'h10325476;
  localparam logic [ByteW-1:0] PAD_BYTE = 8'h80;

  localparam logic [WordW-1:0] K_TABLE [Rounds] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_TABLE [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LEN,
    S_ROUND,
    S_FOLD,
    S_OUT
  } md5_state_t;

  // Where the controller goes once a compression has been folded in.
  typedef enum logic [1:0] {
    AFT_IDLE,
    AFT_PAD,
    AFT_LEN,
    AFT_OUT
  } md5_after_t;

  typedef struct packed {
    logic       absorb;
    logic       pad;
    logic       put_len;
    logic       clr_len;
    logic       start;
    logic       round;
    logic [5:0] rnd;
    logic       fold;
    logic       clr_msg;
    logic [1:0] out_idx;
  } md5_cmd_t;

  typedef struct packed {
    logic blk_end;
    logic pad_two;
  } md5_stat_t;

  function automatic logic [3:0] msg_idx(input logic [5:0] rnd);
    logic [3:0] r;
    logic [3:0] idx;
    r = rnd[3:0];
    case (rnd[5:4])
      2'd0:    idx = r;
      2'd1:    idx = 4'(r * 4'd5 + 4'd1);
      2'd2:    idx = 4'(r * 4'd3 + 4'd5);
      default: idx = 4'(r * 4'd7);
    endcase
    return idx;
  endfunction

  function automatic logic [WordW-1:0] round_f(input logic [1:0] grp,
                                               input logic [WordW-1:0] b,
                                               input logic [WordW-1:0] c,
                                               input logic [WordW-1:0] d);
    logic [WordW-1:0] f;
    case (grp)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v,
                                            input logic [4:0] s);
    logic [2*WordW-1:0] dbl;
    dbl = {v, v} << s;
    return dbl[2*WordW-1:WordW];
  endfunction

endpackage

/* rtl/core/md5_in_if.sv */
// Input channel of the MD5 digest unit: one message byte or end marker per item.
// Stand-alone; no package needed.
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;

  modport source (output valid, output data_byte, output byte_valid, output last,
                  input ready);
  modport sink (input valid, input data_byte, input byte_valid, input last,
                output ready);
endinterface

/* rtl/core/md5_out_if.sv */
// Result channel of the MD5 digest unit: one 32-bit digest word per item.
// Stand-alone; no package needed.
interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

/* rtl/core/md5_message_digest_unit.sv */
// Top level of the MD5 digest unit: joins the controller and the datapath
// to the input and result channels. Depends on md5_pkg, md5_in_if, md5_out_if.
//
// Use: message bytes enter on in_ch, one per item, with byte_valid high.
// An item with last high ends the message; it may carry a final byte or,
// with byte_valid low, be a bare end marker. Four items then leave on
// out_ch: the chaining words A, B, C, D with word_index 0..3, the low byte
// of each word first in the digest, last_word high on the fourth.
// Throughput: an item that does not complete a 64-byte block is taken as
// soon as it is offered. The item that completes a block holds in_ch.ready
// low while the shared round unit runs 64 rounds, one per cycle, and the
// chaining words are updated. After last come a padding step and a
// compression, then a length step and a second compression when fewer
// than nine bytes of room remain in the block; the first digest word is
// then offered, and the digest drains as out_ch takes each word.
// in_ch.ready is low from the end of a message until the fourth digest word
// is taken, so a stalled receiver simply holds the block with its current
// word on out_ch. After that word the unit restarts with the initial
// chaining values and a zero bit count. Synchronous reset does the same
// and leaves no result pending.
module md5_message_digest_unit (
  input logic        clk,
  input logic        rst_n,
  md5_in_if.sink     in_ch,
  md5_out_if.source  out_ch
);
  import md5_pkg::*;

  md5_cmd_t  cmd;
  md5_stat_t stat;

  md5_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_byte_valid (in_ch.byte_valid),
    .in_last       (in_ch.last),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  md5_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_data_byte    (in_ch.data_byte),
    .stat            (stat),
    .out_digest_word (out_ch.digest_word)
  );

  // The word index is the controller's output counter.
  assign out_ch.word_index = cmd.out_idx;
  assign out_ch.last_word  = (cmd.out_idx == 2'd3);

endmodule

/* rtl/core/md5_ctrl.sv */
// Controller of the MD5 digest unit: sequences absorb, padding, the 64 rounds
// and digest output. Depends on md5_pkg.
module md5_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_byte_valid,
  input  logic              in_last,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  md5_pkg::md5_stat_t stat,
  output md5_pkg::md5_cmd_t  cmd
);
  import md5_pkg::*;

  md5_state_t state_r, state_nxt;
  md5_after_t after_r, after_nxt;
  logic [5:0] rnd_r, rnd_nxt;
  logic [1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      after_r <= AFT_IDLE;
      rnd_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    after_nxt   = after_r;
    rnd_nxt     = rnd_r;
    idx_nxt     = idx_r;
    cmd         = '0;
    cmd.rnd     = rnd_r;
    cmd.out_idx = idx_r;
    in_ready    = (state_r == S_IDLE);
    out_valid   = (state_r == S_OUT);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.absorb = in_byte_valid;
          if (in_byte_valid && stat.blk_end) begin
            // This byte fills the block: compress before anything else.
            cmd.start = 1'b1;
            state_nxt = S_ROUND;
            after_nxt = in_last ? AFT_PAD : AFT_IDLE;
          end else if (in_last) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.pad     = 1'b1;
        cmd.put_len = !stat.pad_two;
        cmd.start   = 1'b1;
        after_nxt   = stat.pad_two ? AFT_LEN : AFT_OUT;
        state_nxt   = S_ROUND;
      end
      S_LEN: begin
        cmd.clr_len = 1'b1;
        cmd.start   = 1'b1;
        after_nxt   = AFT_OUT;
        state_nxt   = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'(Rounds - 1)) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        unique case (after_r)
          AFT_IDLE: state_nxt = S_IDLE;
          AFT_PAD:  state_nxt = S_PAD;
          AFT_LEN:  state_nxt = S_LEN;
          AFT_OUT:  state_nxt = S_OUT;
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_OUT: begin
        if (out_ready) begin
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            cmd.clr_msg = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_rnd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_ROUND |-> rnd_r == 6'd0)
    else $error("round counter left nonzero outside the round loop");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a digest is being delivered");

  a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && idx_r == 2'd3 |=> state_r == S_IDLE && idx_r == 2'd0)
    else $error("controller did not return to idle after the final digest word");

  a_out_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FOLD && after_r == AFT_OUT |=> out_valid && idx_r == 2'd0)
    else $error("digest output did not start at word zero");
`endif

endmodule

/* rtl/core/md5_dp.sv */
// Datapath of the MD5 digest unit: block buffer, bit count, chaining words
// and the single round unit. Depends on md5_pkg.
module md5_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  md5_pkg::md5_cmd_t  cmd,
  input  logic [7:0]        in_data_byte,
  output md5_pkg::md5_stat_t stat,
  output logic [31:0]       out_digest_word
);
  import md5_pkg::*;

  logic [WordW-1:0]  chain_r [4];
  logic [WordW-1:0]  block_r [Words];
  logic [WordW-1:0]  block_nxt [Words];
  logic [CountW-1:0] bit_count_r;
  logic [WordW-1:0]  a_r, b_r, c_r, d_r;
  logic [5:0]        pos;
  logic [3:0]        pos_w;
  logic [1:0]        pos_l;
  logic [WordW-1:0]  sum;
  logic [WordW-1:0]  b_new;

  assign pos   = bit_count_r[8:3];
  assign pos_w = pos[5:2];
  assign pos_l = pos[1:0];

  assign stat.blk_end = (pos == 6'd63);
  assign stat.pad_two = (pos[5:3] == 3'b111);

  assign out_digest_word = chain_r[cmd.out_idx];

  // One round: the four-input add, then the rotate and the add of b.
  assign sum   = a_r + round_f(cmd.rnd[5:4], b_r, c_r, d_r) + K_TABLE[cmd.rnd]
                 + block_r[msg_idx(cmd.rnd)];
  assign b_new = b_r + rotl(sum, ROT_TABLE[{cmd.rnd[5:4], cmd.rnd[1:0]}]);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_msg) begin
      chain_r[0]  <= INIT_A;
      chain_r[1]  <= INIT_B;
      chain_r[2]  <= INIT_C;
      chain_r[3]  <= INIT_D;
      bit_count_r <= '0;
    end else begin
      if (cmd.fold) begin
        chain_r[0] <= chain_r[0] + a_r;
        chain_r[1] <= chain_r[1] + b_r;
        chain_r[2] <= chain_r[2] + c_r;
        chain_r[3] <= chain_r[3] + d_r;
      end
      if (cmd.absorb) begin
        bit_count_r <= bit_count_r + CountW'(8);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
    end else if (cmd.round) begin
      a_r <= d_r;
      b_r <= b_new;
      c_r <= b_r;
      d_r <= c_r;
    end
  end

  always_comb begin
    for (int w = 0; w < Words; w++) begin
      block_nxt[w] = block_r[w];
      if (cmd.clr_len) begin
        block_nxt[w] = '0;
      end
      if (cmd.pad) begin
        if (4'(w) > pos_w) begin
          block_nxt[w] = '0;
        end else if (4'(w) == pos_w) begin
          for (int l = 0; l < 4; l++) begin
            if (2'(l) == pos_l) begin
              block_nxt[w][8*l +: 8] = PAD_BYTE;
            end else if (2'(l) > pos_l) begin
              block_nxt[w][8*l +: 8] = '0;
            end
          end
        end
      end
    end
    if (cmd.absorb) begin
      block_nxt[pos_w][8*pos_l +: 8] = in_data_byte;
    end
    if (cmd.put_len || cmd.clr_len) begin
      block_nxt[Words-2] = bit_count_r[WordW-1:0];
      block_nxt[Words-1] = bit_count_r[CountW-1:WordW];
    end
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < Words; w++) begin
      block_r[w] <= block_nxt[w];
    end
  end

endmodule

/* verif/md5_digest_tb_pkg.sv */
// Digest tracker for the MD5 unit testbench: a software MD5 that follows
// the message bytes and holds the digest words still owed. Depends on nothing.
package md5_digest_tb_pkg;

  localparam int unsigned ROT_AMT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  localparam bit [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam bit [7:0]  PAD_MARK = 8'h80;
  localparam int        LEN_SLOT = 56;

  typedef struct {
    bit [31:0] value;
    bit [1:0]  idx;
    bit        is_last;
  } digest_word_t;

  class md5_digest_tracker;
    bit [31:0]    chain [4];
    bit [31:0]    blk [16];
    bit [63:0]    nbits;
    digest_word_t owed_words [$];
    int           mismatches;
    int           words_checked;
    int           messages;
    int           bytes_hashed;
    int           two_block_pads;
    int           multi_block_msgs;
    int           blocks_in_msg;

    function new();
      mismatches       = 0;
      words_checked    = 0;
      messages         = 0;
      bytes_hashed     = 0;
      two_block_pads   = 0;
      multi_block_msgs = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = 32'h67452301;
      chain[1] = 32'hefcdab89;
      chain[2] = 32'h98badcfe;
      chain[3] = 32'h10325476;
      foreach (blk[i]) blk[i] = '0;
      nbits = '0;
      blocks_in_msg = 0;
    endfunction

    function void put_byte(int pos, bit [7:0] v);
      if (pos % 4 == 0) blk[pos / 4] = {24'h0, v};
      else blk[pos / 4][8 * (pos % 4) +: 8] = v;
    endfunction

    function void compress_block();
      bit [31:0] a, b, c, d, f, t, sum;
      int g;
      int s;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int r = 0; r < 64; r++) begin
        case (r / 16)
          0: begin
            f = (b & c) | (~b & d);
            g = r;
          end
          1: begin
            f = (b & d) | (c & ~d);
            g = (5 * r + 1) % 16;
          end
          2: begin
            f = b ^ c ^ d;
            g = (3 * r + 5) % 16;
          end
          default: begin
            f = c ^ (b | ~d);
            g = (7 * r) % 16;
          end
        endcase
        s   = ROT_AMT[(r / 16) * 4 + r % 4];
        sum = a + f + SINE_K[r] + blk[g];
        t   = d;
        d   = c;
        c   = b;
        b   = b + ((sum << s) | (sum >> (32 - s)));
        a   = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      blocks_in_msg++;
    endfunction

    // Follows one accepted input item; an item with last queues the digest.
    function void absorb_item(bit [7:0] data_byte, bit byte_valid, bit last);
      int           pos;
      bit [63:0]    len;
      digest_word_t w;
      if (byte_valid) begin
        pos = int'(nbits[8:3]);
        put_byte(pos, data_byte);
        nbits += 64'd8;
        bytes_hashed++;
        if (pos == 63) compress_block();
      end
      if (!last) return;
      len = nbits;
      pos = int'(nbits[8:3]);
      put_byte(pos, PAD_MARK);
      for (int i = pos + 1; i < 64; i++) put_byte(i, 8'h00);
      if (pos >= LEN_SLOT) begin
        compress_block();
        foreach (blk[i]) blk[i] = '0;
        two_block_pads++;
      end
      blk[14] = len[31:0];
      blk[15] = len[63:32];
      compress_block();
      if (blocks_in_msg > 2) multi_block_msgs++;
      for (int k = 0; k < 4; k++) begin
        w.value   = chain[k];
        w.idx     = 2'(k);
        w.is_last = (k == 3);
        owed_words.push_back(w);
      end
      messages++;
      restart();
    endfunction

    function int pending();
      return owed_words.size();
    endfunction

    task flag_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_word(bit [31:0] value, bit [1:0] idx, bit is_last);
      digest_word_t want;
      if (owed_words.size() == 0) begin
        flag_mismatch($sformatf("digest word %08h index %0d with none owed", value, idx));
        return;
      end
      want = owed_words.pop_front();
      words_checked++;
      if (value != want.value)
        flag_mismatch($sformatf("digest_word %08h, want %08h (index %0d)",
                                value, want.value, want.idx));
      if (idx != want.idx)
        flag_mismatch($sformatf("word_index %0d, want %0d", idx, want.idx));
      if (is_last != want.is_last)
        flag_mismatch($sformatf("last_word %0b, want %0b (index %0d)",
                                is_last, want.is_last, want.idx));
    endtask
  endclass

endpackage

/* verif/tb_top.sv */
// Top of the MD5 digest unit testbench: clock, reset, byte stream driver,
// result sink and watchdog. Depends on md5_digest_tb_pkg, md5_in_if, md5_out_if.
module tb_top;
  import md5_digest_tb_pkg::*;

  // The run stops after this many counted items; ignored items are not counted.
  localparam int ItemTarget = 380;
  // Longest quiet stretch allowed: two compressions, a long sender gap and a
  // long receiver stall fit in this many times over.
  localparam int QuietLimit = 3000;
  // Cycles to watch for stray results once nothing more is owed.
  localparam int TailCycles = 140;

  logic clk = 1'b0;
  logic rst_n;

  md5_in_if  in_ch ();
  md5_out_if out_ch ();

  md5_message_digest_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  md5_digest_tracker tracker = new();

  int items_sent  = 0;
  int quiet_count = 0;

  always #4 clk = ~clk;

  // Sender gap: mostly back to back, often short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Message bytes lean toward the all-zero and all-one patterns now and then.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  // Message lengths: mostly short, a share right at the block and padding
  // boundaries, and a few that run over one or two blocks.
  function automatic int pick_length();
    int r;
    int edges [8];
    edges = '{55, 56, 57, 63, 64, 65, 119, 120};
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 12);
    if (r < 90) return edges[$urandom_range(0, 7)];
    return $urandom_range(13, 130);
  endfunction

  // Drives one item and holds it until the unit takes it. The valid line is
  // only lowered when a gap comes first, so a back-to-back item never sees
  // valid dropped and raised in the same step.
  task automatic send_item(input logic [7:0] data_byte, input logic byte_valid,
                           input logic last, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= data_byte;
    in_ch.byte_valid <= byte_valid;
    in_ch.last       <= last;
    do @(posedge clk); while (!in_ch.ready);
    tracker.absorb_item(data_byte, byte_valid, last);
    if (byte_valid || last) items_sent++;
  endtask

  // Holds the sender back until every owed digest word has been taken.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // One whole message. It ends either on its final byte or with a bare end
  // marker whose data byte is junk. Stray items with neither a byte nor last
  // are mixed in at random; the unit has to ignore them.
  task automatic send_message(input int len, input bit end_on_byte, input bit burst);
    bit end_here;
    end_here = end_on_byte && (len > 0);
    for (int i = 0; i < len; i++) begin
      if (!burst && $urandom_range(0, 19) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, pick_gap());
      send_item(pick_byte(), 1'b1, end_here && (i == len - 1), burst ? 0 : pick_gap());
    end
    if (!end_here)
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, burst ? 0 : pick_gap());
  endtask

  initial begin : stimulus
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= 8'h00;
    in_ch.byte_valid <= 1'b0;
    in_ch.last       <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty message straight after reset; the end marker carries a byte
    // that must be ignored.
    send_item(8'hff, 1'b0, 1'b1, 0);
    // A stray item, then a one-byte message whose only byte also ends it.
    send_item(8'h00, 1'b0, 1'b0, 0);
    send_item(8'h00, 1'b1, 1'b1, 0);
    // One all-ones byte closed by a separate end marker.
    send_item(8'hff, 1'b1, 1'b0, 1);
    send_item(8'h5a, 1'b0, 1'b1, 0);
    // The familiar three-letter message, back to back.
    send_item(8'h61, 1'b1, 1'b0, 0);
    send_item(8'h62, 1'b1, 1'b0, 0);
    send_item(8'h63, 1'b1, 1'b1, 0);
    // The sender waits for the whole backlog before the random part.
    wait_drained();

    while (items_sent < ItemTarget) begin
      send_message(pick_length(), $urandom_range(0, 1) == 1, $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 6) == 0) wait_drained();
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk);

    $display("Covered %0d messages, %0d bytes, %0d digest words checked.",
             tracker.messages, tracker.bytes_hashed, tracker.words_checked);
    $display("%0d messages padded into a second block, %0d spanned several blocks.",
             tracker.two_block_pads, tracker.multi_block_msgs);
    if (tracker.mismatches == 0) begin
      $display("PASS md5_message_digest_unit");
    end else begin
      $display("FAIL md5_message_digest_unit");
    end
    $finish;
  end

  // The receiver alternates ready stretches of random length with stalls.
  // Most stalls are short, a few are long, and some ready stretches last
  // long enough that several digests drain without any stall at all.
  initial begin : result_sink
    int hold;
    int r;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      out_ch.ready <= 1'b1;
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      repeat (hold) @(posedge clk);
      r = $urandom_range(0, 99);
      if (r >= 30) begin
        out_ch.ready <= 1'b0;
        repeat ((r < 92) ? $urandom_range(1, 3) : $urandom_range(20, 100)) @(posedge clk);
      end
    end
  end

  // Every digest word taken by the receiver is checked against the oldest
  // word still owed.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_word(out_ch.digest_word, out_ch.word_index, out_ch.last_word);
  end

  // The run is abandoned if neither channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet_count = 0;
    else
      quiet_count = quiet_count + 1;
    if (quiet_count >= QuietLimit) begin
      $display("Watchdog: no item moved for %0d cycles, %0d digest words still owed.",
               QuietLimit, tracker.pending());
      $display("FAIL md5_message_digest_unit");
      $finish;
    end
  end

endmodule
